// ----- hdl/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Operation codes on the input channel
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_US = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_POLL_LIM = 2'd1;

  localparam logic [7:0] TICKS_PER_US_RST = 8'd1;
  localparam logic [7:0] ACK_POLL_LIM_RST = 8'd250;

  localparam int unsigned WAIT_W = 11;

  // One result item
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_ok;
    logic       ack_timeout;
  } res_t;

endpackage

// ----- hdl/i2cm_seq.sv -----
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer: advances the start, stop, write and read sequences by one
// item per step and presents the line and status state after that item.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [2:0]       operation,
  input  logic [7:0]       tx_byte,
  input  logic             send_ack,
  input  logic             sda_sample,
  input  logic [7:0]       ticks_per_us,
  input  logic [7:0]       ack_poll_lim,
  output i2cm_pkg::res_t   res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_SP_C,
    PH_WR_SETUP, PH_WR_HIGH, PH_WR_LOW, PH_AK_REL, PH_AK_HIGH, PH_AK_POLL,
    PH_RD_LOW, PH_RD_HIGH, PH_RA_SETUP, PH_RA_HIGH
  } phase_t;

  phase_t                        phase, phase_next;
  logic                          cmd_write, cmd_write_next;
  logic [2:0]                    bit_index, bit_index_next;
  logic [i2cm_pkg::WAIT_W-1:0]   wait_cnt, wait_cnt_next;
  logic [7:0]                    poll_cnt, poll_cnt_next;
  logic [7:0]                    shift_reg, shift_reg_next;
  logic                          ack_choice, ack_choice_next;
  logic                          scl, scl_next, sda, sda_next, sda_en, sda_en_next;
  logic                          flag_ok, flag_ok_next, flag_to, flag_to_next;
  logic [7:0]                    rx_hold, rx_hold_next;
  logic                          done_next;

  // Wait lengths: 1, 2 and 4 microseconds; a rate of zero counts as one
  logic [7:0]                    tpu;
  logic [i2cm_pkg::WAIT_W-1:0]   wait_1us, wait_2us, wait_4us, wait_dec;
  logic [7:0]                    poll_base;
  logic                          do_poll;

  assign tpu      = (ticks_per_us == 8'd0) ? 8'd1 : ticks_per_us;
  assign wait_1us = {3'b000, tpu};
  assign wait_2us = {2'b00, tpu, 1'b0};
  assign wait_4us = {1'b0, tpu, 2'b00};
  assign wait_dec = (wait_cnt != '0) ? wait_cnt - 1'b1 : wait_cnt;

  // Compute the state after one item
  always_comb begin
    phase_next      = phase;
    cmd_write_next  = cmd_write;
    bit_index_next  = bit_index;
    wait_cnt_next   = wait_cnt;
    poll_cnt_next   = poll_cnt;
    shift_reg_next  = shift_reg;
    ack_choice_next = ack_choice;
    scl_next        = scl;
    sda_next        = sda;
    sda_en_next     = sda_en;
    flag_ok_next    = flag_ok;
    flag_to_next    = flag_to;
    rx_hold_next    = rx_hold;
    done_next       = 1'b0;
    do_poll         = 1'b0;
    poll_base       = poll_cnt;

    if (step) begin
      unique case (phase)
        PH_IDLE: begin
          if (operation == i2cm_pkg::OP_START || operation == i2cm_pkg::OP_STOP ||
              operation == i2cm_pkg::OP_WRITE || operation == i2cm_pkg::OP_READ) begin
            cmd_write_next = (operation == i2cm_pkg::OP_WRITE);
            bit_index_next = '0;
            poll_cnt_next  = '0;
          end
          case (operation)
            i2cm_pkg::OP_START: begin
              sda_en_next = 1'b1; sda_next = 1'b1; scl_next = 1'b1;
              wait_cnt_next = wait_4us; phase_next = PH_ST_A;
            end
            i2cm_pkg::OP_STOP: begin
              sda_en_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
              wait_cnt_next = wait_4us; phase_next = PH_SP_A;
            end
            i2cm_pkg::OP_WRITE: begin
              flag_ok_next = 1'b0; flag_to_next = 1'b0;
              sda_en_next = 1'b1; scl_next = 1'b0; sda_next = tx_byte[7];
              shift_reg_next = {tx_byte[6:0], 1'b0};
              wait_cnt_next = wait_2us; phase_next = PH_WR_SETUP;
            end
            i2cm_pkg::OP_READ: begin
              ack_choice_next = send_ack;
              shift_reg_next = '0;
              sda_en_next = 1'b0; scl_next = 1'b0;
              wait_cnt_next = wait_2us; phase_next = PH_RD_LOW;
            end
            default: ;
          endcase
        end
        PH_AK_POLL: do_poll = 1'b1;
        default: begin
          wait_cnt_next = wait_dec;
          if (wait_dec == '0) begin
            unique case (phase)
              PH_ST_A: begin
                sda_next = 1'b0; wait_cnt_next = wait_4us; phase_next = PH_ST_B;
              end
              PH_ST_B: begin
                scl_next = 1'b0; phase_next = PH_IDLE; done_next = 1'b1;
              end
              PH_SP_A: begin
                scl_next = 1'b1; wait_cnt_next = wait_4us; phase_next = PH_SP_B;
              end
              PH_SP_B: begin
                sda_next = 1'b1; wait_cnt_next = wait_4us; phase_next = PH_SP_C;
              end
              PH_SP_C: begin
                if (cmd_write) flag_to_next = 1'b1;
                phase_next = PH_IDLE; done_next = 1'b1;
              end
              PH_WR_SETUP: begin
                scl_next = 1'b1; wait_cnt_next = wait_2us; phase_next = PH_WR_HIGH;
              end
              PH_WR_HIGH: begin
                scl_next = 1'b0; wait_cnt_next = wait_2us; phase_next = PH_WR_LOW;
              end
              PH_WR_LOW: begin
                if (bit_index != 3'd7) begin
                  bit_index_next = bit_index + 1'b1;
                  sda_en_next = 1'b1; scl_next = 1'b0; sda_next = shift_reg[7];
                  shift_reg_next = {shift_reg[6:0], 1'b0};
                  wait_cnt_next = wait_2us; phase_next = PH_WR_SETUP;
                end else begin
                  sda_en_next = 1'b1; sda_next = 1'b1;
                  wait_cnt_next = wait_2us; phase_next = PH_AK_REL;
                end
              end
              PH_AK_REL: begin
                sda_en_next = 1'b0; scl_next = 1'b1;
                wait_cnt_next = wait_2us; phase_next = PH_AK_HIGH;
              end
              PH_AK_HIGH: begin
                phase_next = PH_AK_POLL;
                poll_base = '0;
                poll_cnt_next = '0;
                do_poll = 1'b1;
              end
              PH_RD_LOW: begin
                scl_next = 1'b1; wait_cnt_next = wait_1us; phase_next = PH_RD_HIGH;
              end
              PH_RD_HIGH: begin
                shift_reg_next = {shift_reg[6:0], sda_sample};
                scl_next = 1'b0;
                if (bit_index != 3'd7) begin
                  bit_index_next = bit_index + 1'b1;
                  wait_cnt_next = wait_2us; phase_next = PH_RD_LOW;
                end else begin
                  sda_en_next = 1'b1; sda_next = ~ack_choice;
                  wait_cnt_next = wait_2us; phase_next = PH_RA_SETUP;
                end
              end
              PH_RA_SETUP: begin
                scl_next = 1'b1; wait_cnt_next = wait_2us; phase_next = PH_RA_HIGH;
              end
              PH_RA_HIGH: begin
                scl_next = 1'b0; rx_hold_next = shift_reg;
                phase_next = PH_IDLE; done_next = 1'b1;
              end
              default: phase_next = PH_IDLE;
            endcase
          end
        end
      endcase

      // Acknowledge poll: low SDA ends the write, too many high polls stop the bus
      if (do_poll) begin
        if (!sda_sample) begin
          scl_next = 1'b0; flag_ok_next = 1'b1;
          phase_next = PH_IDLE; done_next = 1'b1;
        end else if (poll_base >= ack_poll_lim) begin
          sda_en_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
          wait_cnt_next = wait_4us; phase_next = PH_SP_A;
        end else begin
          poll_cnt_next = poll_base + 1'b1;
        end
      end
    end
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      cmd_write  <= 1'b0;
      bit_index  <= '0;
      wait_cnt   <= '0;
      poll_cnt   <= '0;
      shift_reg  <= '0;
      ack_choice <= 1'b0;
      scl        <= 1'b1;
      sda        <= 1'b1;
      sda_en     <= 1'b1;
      flag_ok    <= 1'b0;
      flag_to    <= 1'b0;
      rx_hold    <= '0;
    end else begin
      phase      <= phase_next;
      cmd_write  <= cmd_write_next;
      bit_index  <= bit_index_next;
      wait_cnt   <= wait_cnt_next;
      poll_cnt   <= poll_cnt_next;
      shift_reg  <= shift_reg_next;
      ack_choice <= ack_choice_next;
      scl        <= scl_next;
      sda        <= sda_next;
      sda_en     <= sda_en_next;
      flag_ok    <= flag_ok_next;
      flag_to    <= flag_to_next;
      rx_hold    <= rx_hold_next;
    end
  end

  // Result of this item, taken by the output queue on the same edge
  always_comb begin
    res.scl_level        = scl_next;
    res.sda_level        = sda_next;
    res.sda_drive_enable = sda_en_next;
    res.busy_res         = (phase_next != PH_IDLE);
    res.done_res         = done_next;
    res.rx_byte          = rx_hold_next;
    res.ack_ok           = flag_ok_next;
    res.ack_timeout      = flag_to_next;
  end

`ifndef SYNTHESIS
  // A running wait never outlasts four microseconds
  a_wait_bound: assert property (@(posedge clk) disable iff (rst)
    wait_cnt <= wait_4us || !$stable(ticks_per_us))
    else $error("wait counter beyond longest delay");

  // Polling only follows the acknowledge high time
  a_poll_entry: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_AK_POLL && $past(phase) != PH_AK_POLL) |-> $past(phase) == PH_AK_HIGH)
    else $error("poll phase entered from wrong phase");

  // Master releases SDA only while sampling the slave
  a_release: assert property (@(posedge clk) disable iff (rst)
    (!sda_en && phase != PH_IDLE) |->
      (phase == PH_AK_HIGH || phase == PH_AK_POLL || phase == PH_RD_LOW ||
       phase == PH_RD_HIGH))
    else $error("SDA released outside a receive phase");
`endif

endmodule

// ----- hdl/i2c_master_byte_engine_unit.sv -----
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_unit
// I2C master byte engine: start, stop, byte write with acknowledge check
// and byte read, timed by tick items.
// ----------------------------------------------------------------------------
//  Channel  Handshake               Payload
//  in       in_valid / in_ready     operation, tx_byte, send_ack, sda_sample
//  out      out_valid / out_ready   scl_level .. ack_timeout, one per in item
//  cfg      cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
//  One item per clock: each transfer is applied to the sequencer in its cycle
//  and its result lands in a two-entry output queue on the same edge.
//  The queue lets input continue while one result waits; input stalls only
//  when both entries are full.
//  Reset: sequencer SCL and SDA high and driven, sequencer idle, queue empty.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       operation,
  input  logic [7:0]                       tx_byte,
  input  logic                             send_ack,
  input  logic                             sda_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             scl_level,
  output logic                             sda_level,
  output logic                             sda_drive_enable,
  output logic                             busy_res,
  output logic                             done_res,
  output logic [7:0]                       rx_byte,
  output logic                             ack_ok,
  output logic                             ack_timeout,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                       cfg_data
);

  logic           in_xfer, out_xfer;
  logic [7:0]     ticks_per_us, ack_poll_lim;
  i2cm_pkg::res_t step_res;
  i2cm_pkg::res_t q0, q1;
  logic [1:0]     q_cnt;
  logic [1:0]     wr_slot;

  assign cfg_ready = 1'b1;
  assign in_ready  = (q_cnt != 2'd2);
  assign out_valid = (q_cnt != 2'd0);
  assign in_xfer   = in_valid & in_ready;
  assign out_xfer  = out_valid & out_ready;
  assign wr_slot   = q_cnt - {1'b0, out_xfer};

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us <= i2cm_pkg::TICKS_PER_US_RST;
      ack_poll_lim <= i2cm_pkg::ACK_POLL_LIM_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        i2cm_pkg::REG_TICKS_PER_US: ticks_per_us <= cfg_data;
        i2cm_pkg::REG_ACK_POLL_LIM: ack_poll_lim <= cfg_data;
        default: ;
      endcase
    end
  end

  i2cm_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .step         (in_xfer),
    .operation    (operation),
    .tx_byte      (tx_byte),
    .send_ack     (send_ack),
    .sda_sample   (sda_sample),
    .ticks_per_us (ticks_per_us),
    .ack_poll_lim (ack_poll_lim),
    .res          (step_res)
  );

  // Advance the output queue: drop the head on a transfer, append new result
  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0;
    end else begin
      q_cnt <= q_cnt + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && wr_slot == 2'd0) begin
      q0 <= step_res;
    end else if (out_xfer) begin
      q0 <= q1;
    end
    if (in_xfer && wr_slot != 2'd0) begin
      q1 <= step_res;
    end
  end

  assign scl_level        = q0.scl_level;
  assign sda_level        = q0.sda_level;
  assign sda_drive_enable = q0.sda_drive_enable;
  assign busy_res         = q0.busy_res;
  assign done_res         = q0.done_res;
  assign rx_byte          = q0.rx_byte;
  assign ack_ok           = q0.ack_ok;
  assign ack_timeout      = q0.ack_timeout;

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt != 2'd3)
    else $error("output queue overflow");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> !busy_res)
    else $error("done reported while still busy");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(ack_ok && ack_timeout))
    else $error("ack ok and ack timeout both set");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> out_valid)
    else $error("accepted item left no result");
`endif

endmodule
